@@ rtl/core/fdt_pkg.sv @@
package fdt_pkg;

   localparam int DEFAULT_SLOTS         = 64;
   localparam int DEFAULT_POSITION_BITS = 24;
   localparam int VALUE_BITS            = 24;
   localparam int GROUP_SIZE            = 16;
   localparam int GROUP_IDX_BITS        = $clog2(GROUP_SIZE);

   typedef enum logic [2:0] {
      FN_OPEN  = 3'd0,
      FN_CLOSE = 3'd1,
      FN_SEEK  = 3'd2,
      FN_TELL  = 3'd3,
      FN_QUERY = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_FD    = 3'd1,
      ST_CLOSED    = 3'd2,
      ST_ALREADY   = 3'd3,
      ST_FULL      = 3'd4,
      ST_BAD_POS   = 3'd5,
      ST_BAD_INODE = 3'd6
   } status_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

@@ rtl/core/file_descriptor_table_core.sv @@
// Open-file descriptor table.
// Request channel (req_*): func, descriptor, inode_number, position and
// file_size; a transaction completes when req_valid is high and req_stall low.
// Response channel (rsp_*): status and value, one response per request,
// in request order; the receiver holds it back with rsp_stall.
// A request is handled in a capture step (request registers, memory read and
// free-slot group search), then an execute step (table update, response
// registered); execute waits while an earlier response is held back.
// req_stall is high in the execute state, so requests are taken one at a
// time; a new request is still accepted while a finished response waits.
// While rsp_stall holds a response, the next request waits in execute.
// Reset clears every slot valid bit, every inode-open bit and rsp_valid; slot
// inode and position storage is not cleared and is read only from open slots.
module file_descriptor_table_core #(
   parameter int SLOTS         = fdt_pkg::DEFAULT_SLOTS,
   parameter int POSITION_BITS = fdt_pkg::DEFAULT_POSITION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_descriptor,
   input  logic [7:0]  req_inode_number,
   input  logic [23:0] req_position,
   input  logic [23:0] req_file_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [23:0] rsp_value
);

   fdt_pkg::ctrl_cmd_type cmd;

   fdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   fdt_dp #(
      .SLOTS         (SLOTS),
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_func         (req_func),
      .req_descriptor   (req_descriptor),
      .req_inode_number (req_inode_number),
      .req_position     (req_position),
      .req_file_size    (req_file_size),
      .rsp_status       (rsp_status),
      .rsp_value        (rsp_value)
   );

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.execute))
      else $error("capture and execute in the same cycle");

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid)
      else $error("executed transaction produced no response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd.execute)
      else $error("pending response overwritten");

   a_capture_then_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> req_stall)
      else $error("request channel open while a transaction is in progress");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= 3'd6))
      else $error("response status out of range");
`endif

endmodule

@@ rtl/core/fdt_ctrl.sv @@
module fdt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fdt_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/fdt_dp.sv @@
module fdt_dp #(
   parameter int SLOTS         = fdt_pkg::DEFAULT_SLOTS,
   parameter int POSITION_BITS = fdt_pkg::DEFAULT_POSITION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fdt_pkg::ctrl_cmd_type               cmd,
   input  logic [2:0]                          req_func,
   input  logic [7:0]                          req_descriptor,
   input  logic [7:0]                          req_inode_number,
   input  logic [23:0]                         req_position,
   input  logic [23:0]                         req_file_size,
   output logic [2:0]                          rsp_status,
   output logic [fdt_pkg::VALUE_BITS-1:0]      rsp_value
);

   localparam int IdxW  = $clog2(SLOTS);
   localparam int NGrp  = (SLOTS + fdt_pkg::GROUP_SIZE - 1) / fdt_pkg::GROUP_SIZE;
   localparam int GrpW  = (NGrp > 1) ? $clog2(NGrp) : 1;
   localparam int PadN  = NGrp * fdt_pkg::GROUP_SIZE;
   localparam logic [8:0] Limit = 9'(SLOTS);

   // request registers
   logic [2:0]               func_ff;
   logic [7:0]               desc_ff;
   logic [7:0]               ino_ff;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] size_ff;

   // slot storage
   logic [SLOTS-1:0]         slot_valid_ff, slot_valid_in;
   logic [SLOTS-1:0]         inode_open_ff, inode_open_in;
   logic [IdxW-1:0]          inode_mem_ff [SLOTS];
   logic [POSITION_BITS-1:0] pos_mem_ff [SLOTS];
   logic [IdxW-1:0]          rd_inode_ff;
   logic [POSITION_BITS-1:0] rd_pos_ff;

   // free-slot search, first level registered
   logic [PadN-1:0]                      used_pad;
   logic [NGrp-1:0]                      grp_free_ff, grp_free_in;
   logic [fdt_pkg::GROUP_IDX_BITS-1:0]   grp_idx_ff [NGrp];
   logic [fdt_pkg::GROUP_IDX_BITS-1:0]   grp_idx_in [NGrp];
   logic [GrpW-1:0]                      sel_grp;
   logic                                 any_free;
   logic [IdxW-1:0]                      free_idx;

   // result
   fdt_pkg::status_type                  rsp_status_ff, st;
   logic [fdt_pkg::VALUE_BITS-1:0]       rsp_value_ff, val;

   logic [IdxW-1:0]          idx, ino_idx, wr_addr;
   logic                     desc_bad, ino_bad, slot_ok;
   logic                     valid_set, valid_clr, ino_write, pos_write;
   logic [POSITION_BITS-1:0] wr_pos;

   genvar gi;
   generate
      for (gi = 0; gi < PadN; gi++) begin : g_pad
         if (gi < SLOTS) begin : g_real
            assign used_pad[gi] = slot_valid_ff[gi];
         end else begin : g_fill
            assign used_pad[gi] = 1'b1;
         end
      end
   endgenerate

   always_comb begin
      for (int g = 0; g < NGrp; g++) begin
         grp_free_in[g] = 1'b0;
         grp_idx_in[g]  = '0;
         for (int k = fdt_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
            if (!used_pad[g*fdt_pkg::GROUP_SIZE + k]) begin
               grp_free_in[g] = 1'b1;
               grp_idx_in[g]  = fdt_pkg::GROUP_IDX_BITS'(k);
            end
         end
      end
   end

   always_comb begin
      sel_grp  = '0;
      any_free = |grp_free_ff;
      for (int g = NGrp - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            sel_grp = GrpW'(g);
         end
      end
      free_idx = IdxW'({sel_grp, grp_idx_ff[sel_grp]});
   end

   assign idx      = desc_ff[IdxW-1:0];
   assign ino_idx  = ino_ff[IdxW-1:0];
   assign desc_bad = {1'b0, desc_ff} >= Limit;
   assign ino_bad  = {1'b0, ino_ff} >= Limit;
   assign slot_ok  = slot_valid_ff[idx];

   always_comb begin
      st        = fdt_pkg::ST_OK;
      val       = '0;
      valid_set = 1'b0;
      valid_clr = 1'b0;
      ino_write = 1'b0;
      pos_write = 1'b0;
      wr_addr   = idx;
      wr_pos    = pos_ff;
      case (func_ff)
         fdt_pkg::FN_OPEN: begin
            if (ino_bad) begin
               st = fdt_pkg::ST_BAD_INODE;
            end else if (inode_open_ff[ino_idx]) begin
               st = fdt_pkg::ST_ALREADY;
            end else if (!any_free) begin
               st = fdt_pkg::ST_FULL;
            end else begin
               valid_set = 1'b1;
               ino_write = 1'b1;
               pos_write = 1'b1;
               wr_addr   = free_idx;
               wr_pos    = size_ff;
               val       = fdt_pkg::VALUE_BITS'(free_idx);
            end
         end
         fdt_pkg::FN_CLOSE: begin
            if (desc_bad) begin
               st = fdt_pkg::ST_BAD_FD;
            end else if (!slot_ok) begin
               st = fdt_pkg::ST_CLOSED;
            end else begin
               valid_clr = 1'b1;
            end
         end
         fdt_pkg::FN_SEEK: begin
            if (desc_bad) begin
               st = fdt_pkg::ST_BAD_FD;
            end else if (!slot_ok) begin
               st = fdt_pkg::ST_CLOSED;
            end else if (pos_ff > size_ff) begin
               st = fdt_pkg::ST_BAD_POS;
            end else begin
               pos_write = 1'b1;
               val       = fdt_pkg::VALUE_BITS'(pos_ff);
            end
         end
         fdt_pkg::FN_TELL: begin
            if (desc_bad) begin
               st = fdt_pkg::ST_BAD_FD;
            end else if (!slot_ok) begin
               st = fdt_pkg::ST_CLOSED;
            end else begin
               val = fdt_pkg::VALUE_BITS'(rd_pos_ff);
            end
         end
         fdt_pkg::FN_QUERY: begin
            if (desc_bad) begin
               st = fdt_pkg::ST_BAD_FD;
            end else if (!slot_ok) begin
               st = fdt_pkg::ST_CLOSED;
            end else begin
               val = fdt_pkg::VALUE_BITS'(rd_inode_ff);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      inode_open_in = inode_open_ff;
      if (cmd.execute && valid_set) begin
         slot_valid_in[wr_addr] = 1'b1;
         inode_open_in[ino_idx] = 1'b1;
      end
      if (cmd.execute && valid_clr) begin
         slot_valid_in[idx]         = 1'b0;
         inode_open_in[rd_inode_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         inode_open_ff <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         inode_open_ff <= inode_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff     <= req_func;
         desc_ff     <= req_descriptor;
         ino_ff      <= req_inode_number;
         pos_ff      <= POSITION_BITS'(req_position);
         size_ff     <= POSITION_BITS'(req_file_size);
         grp_free_ff <= grp_free_in;
         grp_idx_ff  <= grp_idx_in;
      end
   end

   // slot memories: one read port at the descriptor, one write port
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_inode_ff <= inode_mem_ff[req_descriptor[IdxW-1:0]];
         rd_pos_ff   <= pos_mem_ff[req_descriptor[IdxW-1:0]];
      end
      if (cmd.execute && ino_write) begin
         inode_mem_ff[wr_addr] <= ino_idx;
      end
      if (cmd.execute && pos_write) begin
         pos_mem_ff[wr_addr] <= wr_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status_ff <= st;
         rsp_value_ff  <= val;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule
